### hdl/mlpfi_pkg.sv
// Shared types and constants for the MLP forward inference block.
// Used by the config register file, the controller, the datapath and the top level.
package mlpfi_pkg;

	localparam int MAX_LAYERS = 4;
	localparam int MAX_WIDTH  = 16;
	localparam int DATA_BITS  = 16;
	localparam int FRAC_BITS  = 8;

	localparam int LAYER_BITS = $clog2(MAX_LAYERS);
	localparam int IDX_BITS   = $clog2(MAX_WIDTH);
	localparam int WADDR_BITS = LAYER_BITS + 2 * IDX_BITS;
	localparam int BADDR_BITS = LAYER_BITS + IDX_BITS;
	localparam int CNT_BITS   = 5;
	localparam int LCNT_BITS  = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 5;
	// exact sum of MAX_WIDTH products plus the shifted bias
	localparam int PROD_BITS  = 2 * DATA_BITS;
	localparam int ACC_BITS   = PROD_BITS + IDX_BITS + 1;
	localparam int DRAIN_CYCLES = 3;
	localparam int DRAIN_BITS   = 2;

	typedef enum logic [1:0] {
		KIND_WEIGHT = 2'd0,
		KIND_BIAS   = 2'd1,
		KIND_SAMPLE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_LAYER_COUNT = 3'd0,
		REG_WIDTH_0     = 3'd1,
		REG_WIDTH_1     = 3'd2,
		REG_WIDTH_2     = 3'd3,
		REG_WIDTH_3     = 3'd4,
		REG_WIDTH_4     = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_COPY,
		ST_OUT
	} state_t;

	// clamped configuration as seen by the controller
	typedef struct packed {
		logic [LCNT_BITS-1:0]                layers;
		logic [MAX_LAYERS:0][CNT_BITS-1:0]   width;
	} cfg_t;

	typedef struct packed {
		logic                  wr_weight;
		logic                  wr_bias;
		logic                  load_elem;
		logic [IDX_BITS-1:0]   elem_idx;
		logic                  mac;
		logic                  first;
		logic                  last;
		logic                  relu;
		logic [LAYER_BITS-1:0] layer;
		logic [IDX_BITS-1:0]   neuron;
		logic [IDX_BITS-1:0]   col;
		logic                  copy;
		logic                  push;
		logic                  push_last;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

### hdl/mlpfi_cfg.sv
// Configuration register file: layer count and layer widths, with range clamping.
// Depends on mlpfi_pkg.
module mlpfi_cfg import mlpfi_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t                     cfg
);

	logic [LCNT_BITS-1:0]              layers_q;
	logic [MAX_LAYERS:0][CNT_BITS-1:0] width_q;
	logic                              wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layers_q <= LCNT_BITS'(1);
			for (int k = 0; k <= MAX_LAYERS; k++) begin
				width_q[k] <= CNT_BITS'(MAX_WIDTH);
			end
		end else if (wr) begin
			if (cfg_index == REG_LAYER_COUNT) begin
				layers_q <= cfg_data[LCNT_BITS-1:0];
			end else if (cfg_index <= REG_WIDTH_4) begin
				width_q[CFG_IDX_BITS'(cfg_index - REG_WIDTH_0)] <= cfg_data;
			end
		end
	end

	// zero acts as one, anything above the maximum as the maximum
	always_comb begin
		if (layers_q == '0) begin
			cfg.layers = LCNT_BITS'(1);
		end else if (layers_q > LCNT_BITS'(MAX_LAYERS)) begin
			cfg.layers = LCNT_BITS'(MAX_LAYERS);
		end else begin
			cfg.layers = layers_q;
		end
		for (int k = 0; k <= MAX_LAYERS; k++) begin
			if (width_q[k] == '0) begin
				cfg.width[k] = CNT_BITS'(1);
			end else if (width_q[k] > CNT_BITS'(MAX_WIDTH)) begin
				cfg.width[k] = CNT_BITS'(MAX_WIDTH);
			end else begin
				cfg.width[k] = width_q[k];
			end
		end
	end

endmodule

### hdl/mlpfi_ctrl.sv
// Controller: input intake, sample element count, layer/neuron/column sequencing
// and output pacing. Drives the datapath by command struct. Depends on mlpfi_pkg.
module mlpfi_ctrl import mlpfi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	output dp_cmd_t    cmd,
	input  dp_stat_t   stat
);

	state_t                state_q, state_d;
	logic [LAYER_BITS-1:0] l_q, l_d;
	logic [IDX_BITS-1:0]   i_q, i_d;
	logic [IDX_BITS-1:0]   j_q, j_d;
	logic [DRAIN_BITS-1:0] drain_q, drain_d;
	logic [CNT_BITS-1:0]   cnt_q, cnt_d;

	logic                  accept;
	logic [CNT_BITS-1:0]   cnt_inc;
	logic [CNT_BITS-1:0]   nin, nout;
	logic                  j_end, i_end, l_end;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign cnt_inc  = cnt_q + CNT_BITS'(1);

	assign nin   = cfg.width[LCNT_BITS'(l_q)];
	assign nout  = cfg.width[LCNT_BITS'(l_q) + LCNT_BITS'(1)];
	assign j_end = ({1'b0, j_q} == nin - CNT_BITS'(1));
	assign i_end = ({1'b0, i_q} == nout - CNT_BITS'(1));
	assign l_end = (LCNT_BITS'(l_q) == cfg.layers - LCNT_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			l_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			drain_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			l_q     <= l_d;
			i_q     <= i_d;
			j_q     <= j_d;
			drain_q <= drain_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		l_d     = l_q;
		i_d     = i_q;
		j_d     = j_q;
		drain_d = drain_q;
		cnt_d   = cnt_q;

		cmd           = '0;
		cmd.elem_idx  = cnt_q[IDX_BITS-1:0];
		cmd.layer     = l_q;
		cmd.neuron    = i_q;
		cmd.col       = j_q;
		cmd.first     = (j_q == '0);
		cmd.last      = j_end;
		cmd.relu      = !l_end;
		cmd.push_last = i_end;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind_t'(kind))
						KIND_WEIGHT: cmd.wr_weight = 1'b1;
						KIND_BIAS:   cmd.wr_bias = 1'b1;
						KIND_SAMPLE: begin
							cmd.load_elem = (cnt_q < CNT_BITS'(MAX_WIDTH));
							if (cnt_inc >= cfg.width[0]) begin
								cnt_d   = '0;
								l_d     = '0;
								i_d     = '0;
								j_d     = '0;
								state_d = ST_MAC;
							end else begin
								cnt_d = cnt_inc;
							end
						end
						KIND_NONE: ;
					endcase
				end
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				if (j_end) begin
					j_d = '0;
					if (i_end) begin
						drain_d = '0;
						state_d = ST_DRAIN;
					end else begin
						i_d = i_q + IDX_BITS'(1);
					end
				end else begin
					j_d = j_q + IDX_BITS'(1);
				end
			end
			ST_DRAIN: begin
				// let the last neuron of the layer reach the output array
				if (drain_q == DRAIN_BITS'(DRAIN_CYCLES - 1)) begin
					state_d = ST_COPY;
				end else begin
					drain_d = drain_q + DRAIN_BITS'(1);
				end
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
				i_d      = '0;
				j_d      = '0;
				if (l_end) begin
					state_d = ST_OUT;
				end else begin
					l_d     = l_q + LAYER_BITS'(1);
					state_d = ST_MAC;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					if (i_end) begin
						i_d     = '0;
						l_d     = '0;
						state_d = ST_IDLE;
					end else begin
						i_d = i_q + IDX_BITS'(1);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### hdl/mlpfi_dp.sv
// Datapath: weight and bias memories, activation arrays, one pipelined
// multiply-accumulate unit, finishing (floor, saturate, ReLU) and output register.
// Depends on mlpfi_pkg; driven by mlpfi_ctrl.
module mlpfi_dp import mlpfi_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_cmd_t                     cmd,
	output dp_stat_t                    stat,
	input  logic [LAYER_BITS-1:0]       layer_select,
	input  logic [IDX_BITS-1:0]         row,
	input  logic [IDX_BITS-1:0]         column,
	input  logic signed [DATA_BITS-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [DATA_BITS-1:0] result_value,
	output logic [IDX_BITS-1:0]         result_index,
	output logic                        last
);

	localparam int HI_BITS = ACC_BITS - (DATA_BITS + FRAC_BITS - 1);

	logic signed [DATA_BITS-1:0] wmem [0:(1 << WADDR_BITS)-1];
	logic signed [DATA_BITS-1:0] bmem [0:(1 << BADDR_BITS)-1];

	logic signed [DATA_BITS-1:0] act_a [0:MAX_WIDTH-1];
	logic signed [DATA_BITS-1:0] act_b [0:MAX_WIDTH-1];

	logic signed [DATA_BITS-1:0] w_s1, b_s1, x_s1;
	logic                        mac_s1, first_s1, last_s1, relu_s1;
	logic [IDX_BITS-1:0]         idx_s1;

	logic signed [PROD_BITS-1:0] prod_s2;
	logic signed [DATA_BITS-1:0] b_s2;
	logic                        mac_s2, first_s2, last_s2, relu_s2;
	logic [IDX_BITS-1:0]         idx_s2;

	logic signed [ACC_BITS-1:0]  acc_q;
	logic                        done_s3, relu_s3;
	logic [IDX_BITS-1:0]         idx_s3;

	logic signed [ACC_BITS-1:0]  bias_ext, prod_ext;
	logic [HI_BITS-1:0]          hi_bits;
	logic signed [DATA_BITS-1:0] fin;

	logic                        out_valid_q;
	logic signed [DATA_BITS-1:0] result_value_q;
	logic [IDX_BITS-1:0]         result_index_q;
	logic                        last_q;

	// parameter memories, no reset
	always_ff @(posedge clk) begin
		if (cmd.wr_weight) begin
			wmem[{layer_select, row, column}] <= value;
		end
		if (cmd.wr_bias) begin
			bmem[{layer_select, row}] <= value;
		end
		w_s1 <= wmem[{cmd.layer, cmd.neuron, cmd.col}];
		b_s1 <= bmem[{cmd.layer, cmd.neuron}];
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		x_s1    <= act_a[cmd.col];
		prod_s2 <= w_s1 * x_s1;
		b_s2    <= b_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			relu_s1  <= 1'b0;
			idx_s1   <= '0;
			mac_s2   <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
			relu_s2  <= 1'b0;
			idx_s2   <= '0;
			done_s3  <= 1'b0;
			relu_s3  <= 1'b0;
			idx_s3   <= '0;
			acc_q    <= '0;
		end else begin
			mac_s1   <= cmd.mac;
			first_s1 <= cmd.first;
			last_s1  <= cmd.last;
			relu_s1  <= cmd.relu;
			idx_s1   <= cmd.neuron;
			mac_s2   <= mac_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			relu_s2  <= relu_s1;
			idx_s2   <= idx_s1;
			done_s3  <= mac_s2 && last_s2;
			relu_s3  <= relu_s2;
			idx_s3   <= idx_s2;
			if (mac_s2) begin
				acc_q <= (first_s2 ? bias_ext : acc_q) + prod_ext;
			end
		end
	end

	assign bias_ext = {{(ACC_BITS - DATA_BITS - FRAC_BITS){b_s2[DATA_BITS-1]}},
		b_s2, {FRAC_BITS{1'b0}}};
	assign prod_ext = {{(ACC_BITS - PROD_BITS){prod_s2[PROD_BITS-1]}}, prod_s2};

	// floor shift by the fraction bits, saturate, optional ReLU
	assign hi_bits = acc_q[ACC_BITS-1:DATA_BITS+FRAC_BITS-1];
	always_comb begin
		if (hi_bits == '0 || hi_bits == '1) begin
			fin = acc_q[DATA_BITS+FRAC_BITS-1:FRAC_BITS];
		end else if (acc_q[ACC_BITS-1]) begin
			fin = {1'b1, {(DATA_BITS-1){1'b0}}};
		end else begin
			fin = {1'b0, {(DATA_BITS-1){1'b1}}};
		end
		if (relu_s3 && fin[DATA_BITS-1]) begin
			fin = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_WIDTH; k++) begin
				act_a[k] <= '0;
				act_b[k] <= '0;
			end
		end else begin
			if (cmd.load_elem) begin
				act_a[cmd.elem_idx] <= value;
			end else if (cmd.copy) begin
				for (int k = 0; k < MAX_WIDTH; k++) begin
					act_a[k] <= act_b[k];
				end
			end
			if (done_s3) begin
				act_b[idx_s3] <= fin;
			end
		end
	end

	// output register
	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			result_value_q <= act_b[cmd.neuron];
			result_index_q <= cmd.neuron;
			last_q         <= cmd.push_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign result_index = result_index_q;
	assign last         = last_q;

endmodule

### hdl/mlp_forward_inference.sv
// Top level of the MLP forward inference block: config registers, controller, datapath.
// Depends on mlpfi_pkg, mlpfi_cfg, mlpfi_ctrl and mlpfi_dp.
//
//   Input channel (in_valid / in_stall) carries weight writes, bias writes and
//   sample elements, one transfer per cycle. The width_0-th element of a sample
//   starts the evaluation; the input stalls until the last result of the sample
//   sits in the output register.
//   One shared multiply-accumulate unit, one product per cycle: layer l runs
//   width_l * width_(l+1) products, then a pipeline drain and an activation copy.
//   After the last copy the output state pushes the first result into the output
//   register. Results leave one per cycle while out_stall is low.
//   Output channel (out_valid / out_stall) is registered; a stall holds the item and
//   pauses result delivery. The next input transfer is taken while the last result
//   still waits.
//   Config writes (cfg_valid / cfg_ready, always ready) act at once; write them only
//   while no sample evaluation or output is pending.
//   Reset clears the activation arrays, the element count and the config registers
//   (1 layer, all widths 16). Weight and bias memories hold garbage until written.
module mlp_forward_inference import mlpfi_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [LAYER_BITS-1:0]       layer_select,
	input  logic [IDX_BITS-1:0]         row,
	input  logic [IDX_BITS-1:0]         column,
	input  logic signed [DATA_BITS-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [DATA_BITS-1:0] result_value,
	output logic [IDX_BITS-1:0]         result_index,
	output logic                        last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	mlpfi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mlpfi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.cmd      (cmd),
		.stat     (stat)
	);

	mlpfi_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.layer_select (layer_select),
		.row          (row),
		.column       (column),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.result_index (result_index),
		.last         (last)
	);

	// a result only appears after the input has been held off
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a preceding busy cycle");

	// while a vector is still being delivered, no input is taken
	a_busy_mid_vector: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |-> in_stall)
		else $error("input taken in the middle of an output vector");

	// the last mark sits on the final neuron of the output layer
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |->
		({1'b0, result_index} == cfg.width[cfg.layers] - CNT_BITS'(1)))
		else $error("last mark on the wrong output index");

endmodule
